// ----- hdl/dpsm_pkg.sv -----
// dpsm_pkg: shared types and codes for the decoded picture store manager
// operation codes, status codes and the time pair held per picture slot
// no dependencies

package dpsm_pkg;

    // operation codes carried in the input item
    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_UPDATE  = 3'd1,
        OP_DROP    = 3'd2,
        OP_DISPLAY = 3'd3,
        OP_GETFREE = 3'd4,
        OP_FLUSH   = 3'd5
    } t_op;

    // status codes carried in the result item
    typedef enum logic [2:0] {
        ST_DONE           = 3'd0,
        ST_FIELD_HELD     = 3'd1,
        ST_FIELD_RETURNED = 3'd2,
        ST_FLUSHED        = 3'd3,
        ST_NOTHING        = 3'd4
    } t_status;

    localparam int TIME_W  = 64;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    // presentation time pair of one slot
    typedef struct packed {
        logic [TIME_W-1:0] stop_t;
        logic [TIME_W-1:0] start_t;
    } t_times;

    // one result item
    typedef struct packed {
        logic [COUNT_W-1:0] waiting_count;
        logic [TIME_W-1:0]  out_stop;
        logic [TIME_W-1:0]  out_start;
        logic               deliver;
        logic [SLOT_W-1:0]  out_slot;
        t_status            status;
    } t_result;

endpackage

// ----- hdl/decoded_picture_store_manager_unit.sv -----
// decoded_picture_store_manager_unit: picture slot store of a decoder output stage
// slot flags and waiting count in registers, slot times in dpsm_times_mem
// depends on dpsm_pkg, dpsm_times_mem, dpsm_min_track
//
//   channel   direction  width  contents
//   s_axis    in         144    operation item
//   m_axis    out        144    result item, one per operation
//   cfg       in         5      max_waiting register write
//
// add, update, drop, flush and a display with too few waiting pictures finish in the idle state;
// their result goes to the holding stage and from there to the output register.
// display next reads the time memory one slot a cycle.
// get free with no field held tests one slot flag a cycle.
// one item at a time; the next item is taken once the result left the holding stage.
// reset (synchronous, low) clears all flags, the count and sets max_waiting to 3.
// a stalled output holds its result; one more result may wait in the holding stage.

module decoded_picture_store_manager_unit #(
    parameter int ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // op[2:0], slot_index[6:3], is_ref[7], is_field[8], start_time[72:9],
    // stop_time[136:73], zero fill[143:137]
    input  logic [143:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status[2:0], out_slot[6:3], deliver[7], out_start[71:8], out_stop[135:72],
    // waiting_count[140:136], zero fill[143:141]
    output logic [143:0] o_m_axis_tdata,
    input  logic         i_cfg_wr_en,
    input  logic [4:0]   i_cfg_wr_data
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KW    = CNT_W + 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHOW,
        S_FREE
    } t_state;

    // input field decode
    dpsm_pkg::t_op     w_op;
    logic [3:0]        w_idx;
    logic              w_is_ref;
    logic              w_is_field;
    dpsm_pkg::t_times  w_times;
    logic [AW+3:0]     w_idx_ext;
    logic [AW-1:0]     w_addr;
    logic              w_in_range;
    logic              w_accept;

    assign w_op          = dpsm_pkg::t_op'(i_s_axis_tdata[2:0]);
    assign w_idx         = i_s_axis_tdata[6:3];
    assign w_is_ref      = i_s_axis_tdata[7];
    assign w_is_field    = i_s_axis_tdata[8];
    assign w_times       = {i_s_axis_tdata[136:73], i_s_axis_tdata[72:9]};
    assign w_idx_ext     = {{AW{1'b0}}, w_idx};
    assign w_addr        = w_idx_ext[AW-1:0];
    assign w_in_range    = w_idx_ext < (AW + 4)'(ENTRIES);

    // state
    t_state                r_state, n_state;
    logic [ENTRIES-1:0]    r_ref, n_ref;
    logic [ENTRIES-1:0]    r_use, n_use;
    logic [ENTRIES-1:0]    r_shown, n_shown;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_fp, n_fp;
    logic [3:0]            r_fs, n_fs;
    logic [4:0]            r_max_wait;
    logic [CNT_W-1:0]      r_scan, n_scan;
    logic                  r_cand_v;
    logic [AW-1:0]         r_cand_idx;
    dpsm_pkg::t_result     r_res, n_res;
    logic                  r_res_v, n_res_v;
    dpsm_pkg::t_result     r_out;
    logic                  r_out_v;
    logic                  w_drain;

    // memory and tracker hookup
    logic                  w_wr_en;
    logic [AW-1:0]         w_scan_addr;
    dpsm_pkg::t_times      w_rd_data;
    logic                  w_found;
    logic [AW-1:0]         w_best_idx;
    dpsm_pkg::t_times      w_best_times;
    logic                  w_scan_issue;
    logic [AW+3:0]         w_best_ext;
    logic [AW+3:0]         w_scan_ext;
    logic [KW-1:0]         w_count_ext;

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_res_v;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_drain         = r_res_v && (!r_out_v || i_m_axis_tready);
    assign w_scan_addr     = r_scan[AW-1:0];
    assign w_scan_issue    = (r_state == S_SCAN) && (r_scan < CNT_W'(ENTRIES));
    assign w_best_ext      = {4'b0, w_best_idx};
    assign w_scan_ext      = {4'b0, w_scan_addr};
    assign w_wr_en         = w_accept && w_in_range &&
        ((w_op == dpsm_pkg::OP_UPDATE) ||
         ((w_op == dpsm_pkg::OP_ADD) && !(w_is_field && !r_fp)));

    dpsm_times_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_times_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_times),
        .i_rd_addr (w_scan_addr),
        .o_rd_data (w_rd_data)
    );

    dpsm_min_track #(
        .AW (AW)
    ) u_min_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_accept),
        .i_cand_valid (r_cand_v),
        .i_cand_idx   (r_cand_idx),
        .i_cand_times (w_rd_data),
        .o_found      (w_found),
        .o_best_idx   (w_best_idx),
        .o_best_times (w_best_times)
    );

    // next state and result
    always_comb begin
        n_state = r_state;
        n_ref   = r_ref;
        n_use   = r_use;
        n_shown = r_shown;
        n_count = r_count;
        n_fp    = r_fp;
        n_fs    = r_fs;
        n_scan  = r_scan;
        n_res   = r_res;
        n_res_v = r_res_v && !w_drain;
        w_count_ext = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res = '0;
                    n_res.status = dpsm_pkg::ST_DONE;
                    n_res_v = 1'b1;
                    case (w_op)
                        dpsm_pkg::OP_ADD: begin
                            if (w_in_range) begin
                                if (w_is_field && !r_fp) begin
                                    n_fp = 1'b1;
                                    n_fs = w_idx;
                                    n_res.status = dpsm_pkg::ST_FIELD_HELD;
                                end else begin
                                    if (!r_use[w_addr] && (r_count < CNT_W'(ENTRIES))) begin
                                        n_count = r_count + CNT_W'(1);
                                    end
                                    n_ref[w_addr]   = w_is_ref;
                                    n_use[w_addr]   = 1'b1;
                                    n_shown[w_addr] = 1'b0;
                                    n_fp = 1'b0;
                                end
                            end
                        end
                        dpsm_pkg::OP_DROP: begin
                            if (w_in_range && r_use[w_addr]) begin
                                n_ref[w_addr] = 1'b0;
                                if (r_shown[w_addr]) begin
                                    n_use[w_addr]   = 1'b0;
                                    n_shown[w_addr] = 1'b0;
                                    if (r_count != '0) begin
                                        n_count = r_count - CNT_W'(1);
                                    end
                                end
                            end
                        end
                        dpsm_pkg::OP_DISPLAY: begin
                            w_count_ext = KW'(r_count);
                            if (w_count_ext > KW'(r_max_wait)) begin
                                n_res_v = r_res_v && !w_drain;
                                n_scan  = '0;
                                n_state = S_SCAN;
                            end else begin
                                n_res.status = dpsm_pkg::ST_NOTHING;
                            end
                        end
                        dpsm_pkg::OP_GETFREE: begin
                            if (r_fp) begin
                                n_res.status   = dpsm_pkg::ST_FIELD_RETURNED;
                                n_res.out_slot = r_fs;
                            end else begin
                                n_res_v = r_res_v && !w_drain;
                                n_scan  = '0;
                                n_state = S_FREE;
                            end
                        end
                        dpsm_pkg::OP_FLUSH: begin
                            n_ref   = '0;
                            n_use   = '0;
                            n_shown = '0;
                            n_count = '0;
                            n_fp    = 1'b0;
                            n_fs    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // last candidate enters the tracker on the edge that leaves this state
                if (r_scan == CNT_W'(ENTRIES)) begin
                    n_state = S_SHOW;
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                end
            end
            S_SHOW: begin
                n_res   = '0;
                n_res_v = 1'b1;
                n_state = S_IDLE;
                if (w_found) begin
                    n_res.status    = dpsm_pkg::ST_DONE;
                    n_res.out_slot  = w_best_ext[3:0];
                    n_res.out_start = w_best_times.start_t;
                    n_res.out_stop  = w_best_times.stop_t;
                    n_res.deliver   = !w_best_times.start_t[63];
                    n_shown[w_best_idx] = 1'b1;
                    if (!r_ref[w_best_idx]) begin
                        n_use[w_best_idx]   = 1'b0;
                        n_shown[w_best_idx] = 1'b0;
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end else begin
                    n_res.status = dpsm_pkg::ST_NOTHING;
                end
            end
            S_FREE: begin
                if (r_scan == CNT_W'(ENTRIES)) begin
                    // no free slot: flush the store
                    n_res   = '0;
                    n_res.status = dpsm_pkg::ST_FLUSHED;
                    n_res_v = 1'b1;
                    n_ref   = '0;
                    n_use   = '0;
                    n_shown = '0;
                    n_count = '0;
                    n_fp    = 1'b0;
                    n_fs    = '0;
                    n_state = S_IDLE;
                end else if (!r_use[w_scan_addr]) begin
                    n_res   = '0;
                    n_res.status   = dpsm_pkg::ST_DONE;
                    n_res.out_slot = w_scan_ext[3:0];
                    n_res_v = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.waiting_count = 5'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ref      <= '0;
            r_use      <= '0;
            r_shown    <= '0;
            r_count    <= '0;
            r_fp       <= 1'b0;
            r_fs       <= '0;
            r_max_wait <= 5'd3;
            r_res_v    <= 1'b0;
            r_out_v    <= 1'b0;
            r_cand_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ref    <= n_ref;
            r_use    <= n_use;
            r_shown  <= n_shown;
            r_count  <= n_count;
            r_fp     <= n_fp;
            r_fs     <= n_fs;
            r_res_v  <= n_res_v;
            r_cand_v <= w_scan_issue && r_use[w_scan_addr] && !r_shown[w_scan_addr];
            if (i_cfg_wr_en) begin
                r_max_wait <= i_cfg_wr_data;
            end
            if (w_drain) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_res      <= n_res;
        r_cand_idx <= w_scan_addr;
        if (w_drain) begin
            r_out <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {3'b0, r_out};

endmodule

// ----- hdl/dpsm_times_mem.sv -----
// dpsm_times_mem: start/stop time store, one write port and one read port
// read data is registered
// depends on dpsm_pkg

module dpsm_times_mem #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  dpsm_pkg::t_times  i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output dpsm_pkg::t_times  o_rd_data
);

    dpsm_pkg::t_times r_mem [ENTRIES];
    dpsm_pkg::t_times r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/dpsm_min_track.sv -----
// dpsm_min_track: running minimum of slot start times over a scan
// keeps the first slot with the smallest signed start, plus its stop time
// depends on dpsm_pkg

module dpsm_min_track #(
    parameter int AW = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_cand_valid,
    input  logic [AW-1:0]     i_cand_idx,
    input  dpsm_pkg::t_times  i_cand_times,
    output logic              o_found,
    output logic [AW-1:0]     o_best_idx,
    output dpsm_pkg::t_times  o_best_times
);

    logic             r_found;
    logic [AW-1:0]    r_best_idx;
    dpsm_pkg::t_times r_best_times;
    logic             w_take;

    // strictly smaller start wins, so ties keep the lower index
    assign w_take = i_cand_valid &&
        (!r_found || ($signed(i_cand_times.start_t) < $signed(r_best_times.start_t)));

    // found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    // best candidate payload
    always_ff @(posedge i_clk) begin
        if (w_take && !i_clear) begin
            r_best_idx   <= i_cand_idx;
            r_best_times <= i_cand_times;
        end
    end

    assign o_found      = r_found;
    assign o_best_idx   = r_best_idx;
    assign o_best_times = r_best_times;

endmodule

// ----- sim/tb_decoded_picture_store_manager_unit.sv -----
// tb_decoded_picture_store_manager_unit: self-checking bench for the picture slot store
// directed cases, then sequences of decoder traffic, checked against an in-bench predictor
// depends on dpsm_pkg and decoded_picture_store_manager_unit
`timescale 1ns / 1ps

module tb_decoded_picture_store_manager_unit;

    localparam int          NSLOTS       = 16;
    localparam int          LIMIT_CYCLES = 1000000;
    localparam logic [63:0] TIME_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TIME_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [143:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [143:0] o_m_axis_tdata;
    logic         i_cfg_wr_en = 1'b0;
    logic [4:0]   i_cfg_wr_data = '0;

    decoded_picture_store_manager_unit #(
        .ENTRIES(NSLOTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always #10 i_clk = ~i_clk;

    // predicted store contents
    bit          pic_ref   [NSLOTS];
    bit          pic_used  [NSLOTS];
    bit          pic_shown [NSLOTS];
    logic [63:0] pic_start [NSLOTS];
    logic [63:0] pic_stop  [NSLOTS];
    int          waiting_pics;
    bit          field_held;
    logic [3:0]  held_slot;
    int          max_waiting_q = 3;

    dpsm_pkg::t_result expected_results[$];
    int          errors = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;
    logic [63:0] pts_clock = '0;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_store();
        for (int i = 0; i < NSLOTS; i++) begin
            pic_ref[i]   = 1'b0;
            pic_used[i]  = 1'b0;
            pic_shown[i] = 1'b0;
        end
        waiting_pics = 0;
        field_held   = 1'b0;
        held_slot    = '0;
    endfunction

    function automatic void release_slot(int s);
        pic_used[s]  = 1'b0;
        pic_shown[s] = 1'b0;
        if (waiting_pics > 0)
            waiting_pics--;
    endfunction

    // applies one operation to the predicted store and returns the result item
    function automatic dpsm_pkg::t_result predict_step(dpsm_pkg::t_op op, logic [3:0] slot,
                                                       bit is_ref, bit is_field,
                                                       logic [63:0] t_start,
                                                       logic [63:0] t_stop);
        dpsm_pkg::t_result r;
        bit      found;
        int      best;
        r      = '0;
        found  = 1'b0;
        best   = 0;
        case (op)
            dpsm_pkg::OP_ADD: begin
                if (is_field && !field_held) begin
                    field_held = 1'b1;
                    held_slot  = slot;
                    r.status   = dpsm_pkg::ST_FIELD_HELD;
                end else begin
                    if (!pic_used[slot] && waiting_pics < NSLOTS)
                        waiting_pics++;
                    pic_ref[slot]   = is_ref;
                    pic_used[slot]  = 1'b1;
                    pic_shown[slot] = 1'b0;
                    pic_start[slot] = t_start;
                    pic_stop[slot]  = t_stop;
                    field_held      = 1'b0;
                end
            end
            dpsm_pkg::OP_UPDATE: begin
                pic_start[slot] = t_start;
                pic_stop[slot]  = t_stop;
            end
            dpsm_pkg::OP_DROP: begin
                if (pic_used[slot]) begin
                    pic_ref[slot] = 1'b0;
                    if (pic_shown[slot])
                        release_slot(slot);
                end
            end
            dpsm_pkg::OP_DISPLAY: begin
                // oldest unshown picture, lowest index on a tie
                if (waiting_pics > max_waiting_q) begin
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (pic_used[i] && !pic_shown[i] &&
                            (!found || $signed(pic_start[i]) < $signed(pic_start[best]))) begin
                            found = 1'b1;
                            best  = i;
                        end
                    end
                end
                if (!found) begin
                    r.status = dpsm_pkg::ST_NOTHING;
                end else begin
                    r.out_slot  = best[3:0];
                    r.out_start = pic_start[best];
                    r.out_stop  = pic_stop[best];
                    r.deliver   = ~pic_start[best][63];
                    pic_shown[best] = 1'b1;
                    if (!pic_ref[best])
                        release_slot(best);
                end
            end
            dpsm_pkg::OP_GETFREE: begin
                if (field_held) begin
                    r.status   = dpsm_pkg::ST_FIELD_RETURNED;
                    r.out_slot = held_slot;
                end else begin
                    r.status = dpsm_pkg::ST_FLUSHED;
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (!found && !pic_used[i]) begin
                            found      = 1'b1;
                            r.status   = dpsm_pkg::ST_DONE;
                            r.out_slot = i[3:0];
                        end
                    end
                    if (!found)
                        clear_store();
                end
            end
            dpsm_pkg::OP_FLUSH: clear_store();
            default: ;
        endcase
        r.waiting_count = waiting_pics[4:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- random helpers

    function automatic int pick_gap();
        if (!idle_on || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 15);
    endfunction

    function automatic logic [63:0] rnd_time();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] rnd_slot();
        return 4'($urandom_range(0, NSLOTS - 1));
    endfunction

    function automatic bit rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [63:0] rnd_duration();
        return 64'($urandom_range(1, 400000));
    endfunction

    // mostly a rising presentation clock with jitter, sometimes extremes or noise
    function automatic logic [63:0] pick_start();
        case ($urandom_range(0, 19))
            0:       return TIME_MIN;
            1:       return TIME_MAX;
            2:       return 64'd0 - 64'($urandom_range(1, 100000));
            3, 4:    return rnd_time();
            default: begin
                pts_clock = pts_clock + 64'($urandom_range(1, 400000));
                return pts_clock - 64'($urandom_range(0, 800000));
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus side

    // sends one item and records its expected result
    task automatic issue_op(input dpsm_pkg::t_op op, input logic [3:0] slot,
                            input bit is_ref, input bit is_field,
                            input logic [63:0] t_start, input logic [63:0] t_stop,
                            output dpsm_pkg::t_result res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'b0, t_stop, t_start, is_field, is_ref, slot, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        res = predict_step(op, slot, is_ref, is_field, t_start, t_stop);
        expected_results.push_back(res);
        items_sent++;
    endtask

    // holds the sender until every expected result has come back
    task automatic drain_results();
        if (expected_results.size() != 0) begin
            i_s_axis_tvalid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge i_clk);
        end
    endtask

    task automatic write_max_waiting(input int value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= 5'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_waiting_q = value;
    endtask

    // ---------------------------------------------------------------- receiver stalls

    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin : result_check
        dpsm_pkg::t_result got;
        dpsm_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[140:0];
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.out_slot !== want.out_slot) begin
                    $error("out_slot: expected %0d, got %0d", want.out_slot, got.out_slot);
                    errors++;
                end
                if (got.deliver !== want.deliver) begin
                    $error("deliver: expected %0d, got %0d", want.deliver, got.deliver);
                    errors++;
                end
                if (got.out_start !== want.out_start) begin
                    $error("out_start: expected %h, got %h", want.out_start, got.out_start);
                    errors++;
                end
                if (got.out_stop !== want.out_stop) begin
                    $error("out_stop: expected %h, got %h", want.out_stop, got.out_stop);
                    errors++;
                end
                if (got.waiting_count !== want.waiting_count) begin
                    $error("waiting_count: expected %0d, got %0d",
                           want.waiting_count, got.waiting_count);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("decoded_picture_store_manager_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // operations on an empty store
    task automatic test_empty_store();
        dpsm_pkg::t_result res;
        issue_op(dpsm_pkg::OP_DISPLAY, 4'd0, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_GETFREE, 4'd15, 1'b1, 1'b1, TIME_MAX, TIME_MIN, res);
        issue_op(dpsm_pkg::OP_DROP, 4'd9, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_UPDATE, 4'd2, 1'b0, 1'b0, 64'd500, 64'd900, res);
        issue_op(dpsm_pkg::OP_FLUSH, 4'd0, 1'b0, 1'b0, '0, '0, res);
    endtask

    // first field held, returned by get free, second field stored
    task automatic test_field_pairs();
        dpsm_pkg::t_result res;
        issue_op(dpsm_pkg::OP_ADD, 4'd5, 1'b1, 1'b1, 64'd1000, 64'd1400, res);
        issue_op(dpsm_pkg::OP_GETFREE, 4'd0, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_ADD, 4'd5, 1'b1, 1'b1, 64'd1000, 64'd1400, res);
        issue_op(dpsm_pkg::OP_ADD, 4'd6, 1'b0, 1'b1, 64'd2000, 64'd2400, res);
        issue_op(dpsm_pkg::OP_FLUSH, 4'd0, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_GETFREE, 4'd0, 1'b0, 1'b0, '0, '0, res);
    endtask

    // display order: extremes, negative start, ties, overwrite, drop of a shown reference
    task automatic test_display_order();
        dpsm_pkg::t_result res;
        write_max_waiting(0);
        issue_op(dpsm_pkg::OP_ADD, 4'd3, 1'b0, 1'b0, TIME_MAX, TIME_MAX, res);
        issue_op(dpsm_pkg::OP_ADD, 4'd1, 1'b1, 1'b0, TIME_MIN, 64'd10, res);
        issue_op(dpsm_pkg::OP_ADD, 4'd2, 1'b0, 1'b0, 64'd100, 64'd200, res);
        issue_op(dpsm_pkg::OP_ADD, 4'd0, 1'b0, 1'b0, 64'd100, 64'd300, res);
        // overwrite of a slot in use keeps the count
        issue_op(dpsm_pkg::OP_ADD, 4'd2, 1'b1, 1'b0, 64'd100, 64'd250, res);
        issue_op(dpsm_pkg::OP_DISPLAY, 4'd0, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_DROP, 4'd1, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_DISPLAY, 4'd0, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_DISPLAY, 4'd0, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_DISPLAY, 4'd0, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_DISPLAY, 4'd0, 1'b0, 1'b0, '0, '0, res);
        issue_op(dpsm_pkg::OP_UPDATE, 4'd2, 1'b0, 1'b0, 64'd0 - 64'd7, 64'd1, res);
        issue_op(dpsm_pkg::OP_DROP, 4'd2, 1'b0, 1'b0, '0, '0, res);
    endtask

    // one decoded picture: get a slot, add a frame or a field pair, maybe display
    task automatic run_decode_cycle();
        dpsm_pkg::t_result res;
        logic [3:0]  slot;
        logic [63:0] ts;
        bit          is_ref;
        bit          second;
        issue_op(dpsm_pkg::OP_GETFREE, rnd_slot(), rnd_bit(), rnd_bit(), rnd_time(),
                 rnd_time(), res);
        slot   = res.out_slot;
        second = (res.status == dpsm_pkg::ST_FIELD_RETURNED);
        is_ref = ($urandom_range(0, 2) == 0);
        ts     = pick_start();
        if (!second && $urandom_range(0, 3) == 0) begin
            issue_op(dpsm_pkg::OP_ADD, slot, is_ref, 1'b1, ts, ts + rnd_duration(), res);
            second = 1'b1;
        end
        issue_op(dpsm_pkg::OP_ADD, slot, is_ref, second ? rnd_bit() : 1'b0, ts,
                 ts + rnd_duration(), res);
        if ($urandom_range(0, 3) != 0)
            issue_op(dpsm_pkg::OP_DISPLAY, rnd_slot(), rnd_bit(), rnd_bit(), rnd_time(),
                     rnd_time(), res);
    endtask

    // drop one reference still held, or a random slot
    task automatic run_drop_ref();
        dpsm_pkg::t_result res;
        int      refs[$];
        for (int i = 0; i < NSLOTS; i++)
            if (pic_used[i] && pic_ref[i])
                refs.push_back(i);
        if (refs.size() != 0)
            issue_op(dpsm_pkg::OP_DROP, 4'(refs[$urandom_range(0, refs.size() - 1)]),
                     rnd_bit(), rnd_bit(), rnd_time(), rnd_time(), res);
        else
            issue_op(dpsm_pkg::OP_DROP, rnd_slot(), rnd_bit(), rnd_bit(), rnd_time(),
                     rnd_time(), res);
    endtask

    // every slot taken, then get free finds none and flushes
    task automatic run_fill_store();
        dpsm_pkg::t_result res;
        logic [63:0] ts;
        for (int i = 0; i < NSLOTS; i++) begin
            ts = pick_start();
            issue_op(dpsm_pkg::OP_ADD, 4'(i), rnd_bit(), 1'b0, ts, ts + rnd_duration(), res);
        end
        issue_op(dpsm_pkg::OP_GETFREE, rnd_slot(), rnd_bit(), rnd_bit(), rnd_time(),
                 rnd_time(), res);
    endtask

    task automatic test_random_traffic(input int max_wait, input int n_items);
        dpsm_pkg::t_result res;
        int          target;
        int          pick;
        logic [63:0] ts;
        write_max_waiting(max_wait);
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                run_decode_cycle();
            end else if (pick < 70) begin
                run_drop_ref();
            end else if (pick < 78) begin
                ts = pick_start();
                issue_op(dpsm_pkg::OP_UPDATE, rnd_slot(), rnd_bit(), rnd_bit(), ts,
                         ts + rnd_duration(), res);
            end else if (pick < 93) begin
                issue_op(dpsm_pkg::t_op'($urandom_range(0, 5)), rnd_slot(), rnd_bit(),
                         rnd_bit(), rnd_time(), rnd_time(), res);
            end else if (pick < 95) begin
                issue_op(dpsm_pkg::OP_FLUSH, rnd_slot(), rnd_bit(), rnd_bit(), rnd_time(),
                         rnd_time(), res);
            end else if (pick < 97) begin
                run_fill_store();
            end else if (idle_on) begin
                drain_results();
            end
        end
    endtask

    // last stretch with both sides at full rate
    task automatic test_back_to_back_traffic();
        idle_on = 1'b0;
        test_random_traffic(2, 350);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_store();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_field_pairs();
        test_display_order();
        test_random_traffic(16, 250);
        test_random_traffic(0, 400);
        test_random_traffic($urandom_range(1, 15), 400);
        test_random_traffic(3, 400);
        test_back_to_back_traffic();

        drain_results();
        repeat (NSLOTS + 8) @(posedge i_clk);
        if (errors == 0)
            $display("decoded_picture_store_manager_unit regression: pass");
        else
            $display("decoded_picture_store_manager_unit regression: fail");
        $finish;
    end

endmodule
